// ===== rtl/rrts_pkg.sv =====
// Package for the round-robin task scheduler: opcodes, task states, defaults.
// No dependencies.
`timescale 1ns / 1ps
package rrts_pkg;
    localparam int MaxTasksDef = 8;
    localparam logic [7:0]  QuantumReset = 8'd10;
    localparam logic [15:0] TimeoutReset = 16'd100;
    localparam logic [31:0] MsPerTick = 32'd10;
    // ceil(2^35 / 10): multiply and keep bits 63..35 to divide by ten
    localparam logic [31:0] DivTenRecip = 32'hCCCC_CCCD;

    typedef enum logic [2:0] {
        OP_TICK = 3'd0, OP_CREATE = 3'd1, OP_SCHED = 3'd2,
        OP_SLEEP = 3'd3, OP_EXIT = 3'd4, OP_BEAT = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        TS_DORMANT = 2'd0, TS_READY = 2'd1, TS_RUNNING = 2'd2, TS_BLOCKED = 2'd3
    } t_task_state;

    localparam logic CFG_QUANTUM = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;
endpackage

// ===== rtl/rrts_div10.sv =====
// Divide by ten through a reciprocal multiply: operand registered, then one
// 32x32 product whose quotient is registered. Depends on rrts_pkg.
`timescale 1ns / 1ps
module rrts_div10 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    import rrts_pkg::*;
    logic [31:0] r_x;
    logic [31:0] r_q;
    logic        r_busy;
    logic [63:0] w_prod;

    // exact for every 32-bit dividend
    assign w_prod = {32'd0, r_x} * {32'd0, DivTenRecip};
    assign o_quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            o_done <= r_busy;
            if (i_start) r_x <= i_dividend;
            if (r_busy) r_q <= {3'd0, w_prod[63:35]};
        end
    end
endmodule

// ===== rtl/round_robin_task_scheduler.sv =====
// Round-robin task scheduler: task table, slot-serial sequencer, result register.
// A tick sweeps the used slots, then updates the quantum; a schedule searches the slots
// for the next ready task; a sleep waits on the reciprocal divide by ten; others go straight to the result.
// One request at a time, the next taken the cycle after the result leaves; the
// tick sweep visits one slot per cycle through the shared compare/update path.
// Synchronous active-low reset clears task states, counters, restores config defaults.
// Depends on rrts_pkg and rrts_div10.
`timescale 1ns / 1ps
module round_robin_task_scheduler #(
    parameter int MAX_TASKS = rrts_pkg::MaxTasksDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_opcode,
    input  logic [2:0]  i_task_index,
    input  logic [31:0] i_stack_pointer,
    input  logic [31:0] i_sleep_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_switch_request,
    output logic [31:0] o_next_stack_pointer,
    output logic [2:0]  o_running_task,
    output logic        o_running_valid,
    output logic        o_status,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);
    import rrts_pkg::*;
    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_TICK = 6'b000010, S_QUANT = 6'b000100,
        S_SCHED = 6'b001000, S_DIV = 6'b010000, S_OUT = 6'b100000
    } t_fsm;

    t_fsm r_st;
    logic [7:0]  r_quantum;
    logic [15:0] r_timeout;
    t_task_state r_ts [MAX_TASKS];
    logic [7:0]  r_rem [MAX_TASKS];
    logic [31:0] r_wake [MAX_TASKS];
    logic [31:0] r_seen [MAX_TASKS];
    logic [31:0] r_ssp [MAX_TASKS];
    logic [31:0] r_isp [MAX_TASKS];
    logic [31:0] r_tick;
    logic [IW-1:0] r_cur;
    logic        r_cur_ok;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_i;
    logic [IW-1:0] r_cand;
    logic [31:0] r_sp;
    logic        r_sw;
    logic        r_stat;

    logic        w_div_done;
    logic [31:0] w_quot;
    logic        w_div_start;
    logic [IW-1:0] w_ii;
    logic [IW-1:0] w_nc;
    logic [31:0] w_dseen;
    logic [31:0] w_dwake;
    logic [31:0] w_t;

    assign w_div_start = (r_st == S_IDLE) && i_valid && (i_opcode == OP_SLEEP) && r_cur_ok;
    rrts_div10 u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_dividend(i_sleep_ms), .o_done(w_div_done), .o_quotient(w_quot)
    );

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_switch_request = r_sw;
    assign o_next_stack_pointer = r_sp;
    assign o_running_task = 3'(r_cur);
    assign o_running_valid = r_cur_ok;
    assign o_status = r_stat;

    assign w_ii = r_i[IW-1:0];
    assign w_nc = (32'(r_cand) + 32'd1 >= 32'(r_cnt)) ? '0 : r_cand + IW'(1);
    assign w_dseen = r_tick - r_seen[w_ii];
    assign w_dwake = r_tick - r_wake[w_ii];
    assign w_t = (w_quot == 32'd0) ? 32'd1 : w_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_quantum <= QuantumReset;
            r_timeout <= TimeoutReset;
            r_tick <= '0;
            r_cur <= '0;
            r_cur_ok <= 1'b0;
            r_cnt <= '0;
            for (int k = 0; k < MAX_TASKS; k++) begin
                r_ts[k] <= TS_DORMANT;
                r_rem[k] <= '0;
                r_wake[k] <= '0;
                r_seen[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_QUANTUM) r_quantum <= i_cfg_wdata[7:0];
                else r_timeout <= i_cfg_wdata;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_sp <= i_stack_pointer;
                        unique case (i_opcode)
                            OP_TICK: begin
                                r_sw <= 1'b0;
                                r_stat <= 1'b0;
                                r_tick <= r_tick + 32'd1;
                                r_i <= '0;
                                r_st <= S_TICK;
                            end
                            OP_CREATE: begin
                                r_sw <= 1'b0;
                                r_st <= S_OUT;
                                if (32'(i_task_index) < MAX_TASKS) begin
                                    r_stat <= 1'b0;
                                    r_ts[i_task_index[IW-1:0]] <= TS_READY;
                                    r_rem[i_task_index[IW-1:0]] <= r_quantum;
                                    r_seen[i_task_index[IW-1:0]] <= r_tick;
                                    r_wake[i_task_index[IW-1:0]] <= '0;
                                    r_ssp[i_task_index[IW-1:0]] <= i_stack_pointer;
                                    r_isp[i_task_index[IW-1:0]] <= i_stack_pointer;
                                    if (32'(i_task_index) + 32'd1 > 32'(r_cnt))
                                        r_cnt <= CW'(32'(i_task_index) + 32'd1);
                                end else r_stat <= 1'b1;
                            end
                            OP_SCHED: begin
                                r_sw <= 1'b0;
                                r_stat <= 1'b0;
                                if (r_cur_ok) begin
                                    r_ssp[r_cur] <= i_stack_pointer;
                                    if (r_ts[r_cur] == TS_RUNNING) r_ts[r_cur] <= TS_READY;
                                end
                                if (r_cnt != '0) begin
                                    r_cand <= (r_cur_ok && 32'(r_cur) < 32'(r_cnt))
                                        ? r_cur : IW'(r_cnt - CW'(1));
                                    r_i <= '0;
                                    r_st <= S_SCHED;
                                end else r_st <= S_OUT;
                            end
                            OP_SLEEP: begin
                                r_sw <= 1'b0;
                                if (r_cur_ok) begin
                                    r_stat <= 1'b0;
                                    r_st <= S_DIV;
                                end else begin
                                    r_stat <= 1'b1;
                                    r_st <= S_OUT;
                                end
                            end
                            OP_EXIT: begin
                                r_st <= S_OUT;
                                if (r_cur_ok) begin
                                    r_ts[r_cur] <= TS_DORMANT;
                                    r_sw <= 1'b1;
                                    r_stat <= 1'b0;
                                end else begin
                                    r_sw <= 1'b0;
                                    r_stat <= 1'b1;
                                end
                            end
                            OP_BEAT: begin
                                r_sw <= 1'b0;
                                r_st <= S_OUT;
                                if (r_cur_ok) begin
                                    r_seen[r_cur] <= r_tick;
                                    r_stat <= 1'b0;
                                end else r_stat <= 1'b1;
                            end
                            default: begin
                                r_sw <= 1'b0;
                                r_stat <= 1'b1;
                                r_st <= S_OUT;
                            end
                        endcase
                    end
                end
                S_TICK: begin
                    // one slot per cycle through the shared compare path
                    if (r_i >= r_cnt) r_st <= S_QUANT;
                    else begin
                        if (r_ts[w_ii] == TS_BLOCKED) begin
                            r_seen[w_ii] <= r_tick;
                            if (!w_dwake[31]) begin
                                r_wake[w_ii] <= '0;
                                r_ts[w_ii] <= TS_READY;
                            end
                        end else if (r_ts[w_ii] != TS_DORMANT &&
                                     w_dseen > 32'(r_timeout)) begin
                            r_ts[w_ii] <= TS_READY;
                            r_rem[w_ii] <= r_quantum;
                            r_seen[w_ii] <= r_tick;
                            r_wake[w_ii] <= '0;
                            r_ssp[w_ii] <= r_isp[w_ii];
                        end
                        r_i <= r_i + CW'(1);
                    end
                end
                S_QUANT: begin
                    if (r_cur_ok && r_rem[r_cur] >= 8'd2) begin
                        r_rem[r_cur] <= r_rem[r_cur] - 8'd1;
                        r_sw <= 1'b0;
                    end else begin
                        if (r_cur_ok) r_rem[r_cur] <= r_quantum;
                        r_sw <= 1'b1;
                    end
                    r_st <= S_OUT;
                end
                S_SCHED: begin
                    // advance the candidate; stop on the first ready slot
                    if (r_i >= r_cnt) r_st <= S_OUT;
                    else begin
                        r_cand <= w_nc;
                        r_i <= r_i + CW'(1);
                        if (r_ts[w_nc] == TS_READY) begin
                            r_cur <= w_nc;
                            r_cur_ok <= 1'b1;
                            r_ts[w_nc] <= TS_RUNNING;
                            r_rem[w_nc] <= r_quantum;
                            r_sp <= r_ssp[w_nc];
                            r_st <= S_OUT;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_wake[r_cur] <= r_tick + w_t;
                        r_ts[r_cur] <= TS_BLOCKED;
                        r_sw <= 1'b1;
                        r_st <= S_OUT;
                    end
                end
                S_OUT: if (i_ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_cur_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_ok |-> 32'(r_cur) < 32'(r_cnt)) else $error("current slot beyond count");
    a_sched_nosw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_SCHED) |=> !r_sw) else $error("schedule raised switch");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT && !i_ready) |=> (r_st == S_OUT)) else $error("result dropped");
endmodule

// ===== tb/tb_round_robin_task_scheduler.sv =====
// Self-checking testbench for the round-robin task scheduler.
// Holds its own copy of the task table to predict every result; depends on rrts_pkg and the DUT.
`timescale 1ns / 1ps

module tb_round_robin_task_scheduler;
    import rrts_pkg::*;

    typedef struct packed {
        logic        sw;
        logic [31:0] nsp;
        logic [2:0]  task_id;
        logic        present;
        logic        ignored;
    } t_sched_result;

    class sched_scoreboard;
        t_task_state   slot_state [8];
        logic [7:0]    quantum_left [8];
        logic [31:0]   wake_at [8];
        logic [31:0]   seen_at [8];
        logic [31:0]   saved_sp [8];
        logic [31:0]   start_sp [8];
        logic [31:0]   tick_now;
        logic [2:0]    cur_slot;
        bit            cur_ok;
        int unsigned   slots_used;
        logic [7:0]    quantum;
        logic [15:0]   timeout;
        t_sched_result expected_q[$];
        int            errors;
        int            checked;

        function new();
            for (int i = 0; i < 8; i++) begin
                slot_state[i] = TS_DORMANT;
                quantum_left[i] = '0;
                wake_at[i] = '0;
                seen_at[i] = '0;
                saved_sp[i] = '0;
                start_sp[i] = '0;
            end
            tick_now = '0;
            cur_slot = '0;
            cur_ok = 0;
            slots_used = 0;
            quantum = QuantumReset;
            timeout = TimeoutReset;
            errors = 0;
            checked = 0;
        endfunction

        function void load_slot(int i, logic [31:0] sp);
            slot_state[i] = TS_READY;
            quantum_left[i] = quantum;
            seen_at[i] = tick_now;
            wake_at[i] = '0;
            start_sp[i] = sp;
            saved_sp[i] = sp;
        endfunction

        function logic advance_tick();
            logic [31:0] diff;
            tick_now = tick_now + 32'd1;
            for (int i = 0; i < slots_used; i++) begin
                if (slot_state[i] == TS_BLOCKED) begin
                    seen_at[i] = tick_now;
                    diff = tick_now - wake_at[i];
                    if (diff < 32'h8000_0000) begin
                        wake_at[i] = '0;
                        slot_state[i] = TS_READY;
                    end
                end else if (slot_state[i] != TS_DORMANT) begin
                    diff = tick_now - seen_at[i];
                    if (diff > {16'd0, timeout})
                        load_slot(i, start_sp[i]);
                end
            end
            if (cur_ok) begin
                if (quantum_left[cur_slot] >= 8'd2) begin
                    quantum_left[cur_slot] = quantum_left[cur_slot] - 8'd1;
                    return 1'b0;
                end
                quantum_left[cur_slot] = quantum;
            end
            return 1'b1;
        endfunction

        function logic [31:0] pick_next(logic [31:0] sp);
            int unsigned cand;
            if (cur_ok) begin
                saved_sp[cur_slot] = sp;
                if (slot_state[cur_slot] == TS_RUNNING)
                    slot_state[cur_slot] = TS_READY;
            end
            if (slots_used == 0)
                return sp;
            cand = (cur_ok && cur_slot < slots_used) ? cur_slot : slots_used - 1;
            for (int k = 0; k < slots_used; k++) begin
                cand = (cand + 1) % slots_used;
                if (slot_state[cand] == TS_READY) begin
                    cur_slot = cand[2:0];
                    cur_ok = 1;
                    slot_state[cand] = TS_RUNNING;
                    quantum_left[cand] = quantum;
                    return saved_sp[cand];
                end
            end
            return sp;
        endfunction

        function void note_request(logic [2:0] op, logic [2:0] idx, logic [31:0] sp,
                                   logic [31:0] ms);
            t_sched_result r;
            logic [31:0] span;
            r.sw = 0;
            r.nsp = sp;
            r.ignored = 0;
            case (op)
                OP_TICK: r.sw = advance_tick();
                OP_CREATE: begin
                    load_slot(idx, sp);
                    if (idx + 1 > slots_used)
                        slots_used = idx + 1;
                end
                OP_SCHED: r.nsp = pick_next(sp);
                OP_SLEEP: begin
                    if (cur_ok) begin
                        span = ms / MsPerTick;
                        if (span == 0)
                            span = 1;
                        wake_at[cur_slot] = tick_now + span;
                        slot_state[cur_slot] = TS_BLOCKED;
                        r.sw = 1;
                    end else begin
                        r.ignored = 1;
                    end
                end
                OP_EXIT: begin
                    if (cur_ok) begin
                        slot_state[cur_slot] = TS_DORMANT;
                        r.sw = 1;
                    end else begin
                        r.ignored = 1;
                    end
                end
                OP_BEAT: begin
                    if (cur_ok)
                        seen_at[cur_slot] = tick_now;
                    else
                        r.ignored = 1;
                end
                default: r.ignored = 1;
            endcase
            r.task_id = cur_slot;
            r.present = cur_ok;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_sched_result got);
            t_sched_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.sw !== want.sw) begin
                $display("%0t: switch_request exp %0d got %0d", $time, want.sw, got.sw);
                errors++;
            end
            if (got.nsp !== want.nsp) begin
                $display("%0t: next_stack_pointer exp %h got %h", $time, want.nsp, got.nsp);
                errors++;
            end
            if (got.task_id !== want.task_id) begin
                $display("%0t: running_task exp %0d got %0d", $time, want.task_id,
                         got.task_id);
                errors++;
            end
            if (got.present !== want.present) begin
                $display("%0t: running_valid exp %0d got %0d", $time, want.present,
                         got.present);
                errors++;
            end
            if (got.ignored !== want.ignored) begin
                $display("%0t: status exp %0d got %0d", $time, want.ignored, got.ignored);
                errors++;
            end
        endfunction
    endclass

    localparam logic [2:0] OpUndefLo = 3'd6;
    localparam logic [2:0] OpUndefHi = 3'd7;
    localparam int         CycleLimit = 600000;
    localparam int         DrainCycles = 60;
    localparam int         PhaseItems = 320;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_opcode;
    logic [2:0]  i_task_index;
    logic [31:0] i_stack_pointer;
    logic [31:0] i_sleep_ms;
    logic        o_valid;
    logic        i_ready;
    logic        o_switch_request;
    logic [31:0] o_next_stack_pointer;
    logic [2:0]  o_running_task;
    logic        o_running_valid;
    logic        o_status;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_wdata;

    sched_scoreboard sched_sb;
    bit  calm;
    bit  hold_off;
    int  cycles = 0;
    int  requests_sent;

    round_robin_task_scheduler DUT (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid && i_ready)
            sched_sb.check_result({o_switch_request, o_next_stack_pointer, o_running_task,
                                   o_running_valid, o_status});

    // Result side: random stalls, or a long hold-off when asked for.
    initial begin
        i_ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_ready = 0;
                repeat (400) @(negedge i_clk);
                hold_off = 0;
            end else begin
                i_ready = calm || ($urandom_range(0, 99) >= 36);
            end
        end
    end

    task automatic send_request(logic [2:0] op, logic [2:0] idx, logic [31:0] sp,
                                logic [31:0] ms);
        if (!calm && $urandom_range(0, 99) < 36) begin
            i_valid = 0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_opcode = op;
        i_task_index = idx;
        i_stack_pointer = sp;
        i_sleep_ms = ms;
        i_valid = 1;
        do @(posedge i_clk); while (!o_ready);
        sched_sb.note_request(op, idx, sp, ms);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic random_request();
        int unsigned pick;
        logic [31:0] ms;
        logic [2:0]  idx;
        pick = $urandom_range(0, 99);
        ms = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300);
        idx = 3'($urandom_range(0, 7));
        if (pick < 45)
            send_request(OP_TICK, idx, $urandom, $urandom);
        else if (pick < 57)
            send_request(OP_CREATE, idx, $urandom, $urandom);
        else if (pick < 75)
            send_request(OP_SCHED, idx, $urandom, $urandom);
        else if (pick < 83)
            send_request(OP_BEAT, idx, $urandom, $urandom);
        else if (pick < 90)
            send_request(OP_SLEEP, idx, $urandom, ms);
        else if (pick < 94)
            send_request(OP_EXIT, idx, $urandom, $urandom);
        else if (pick < 96)
            send_request($urandom_range(0, 1) ? OpUndefHi : OpUndefLo,
                         idx, $urandom, $urandom);
        else
            send_request(3'($urandom_range(0, 7)), idx, $urandom, $urandom);
    endtask

    task automatic drain();
        i_valid = 0;
        while (sched_sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic write_config(logic [7:0] q, logic [15:0] t);
        i_cfg_we = 1;
        i_cfg_index = CFG_QUANTUM;
        i_cfg_wdata = {8'd0, q};
        @(negedge i_clk);
        i_cfg_index = CFG_TIMEOUT;
        i_cfg_wdata = t;
        @(negedge i_clk);
        i_cfg_we = 0;
        sched_sb.quantum = q;
        sched_sb.timeout = t;
    endtask

    initial begin
        logic [7:0]  q_set [6];
        logic [15:0] t_set [6];
        sched_sb = new();
        q_set = '{8'd1, 8'd255, 8'd4, 8'd3, 8'd2, 8'd10};
        t_set = '{16'd1, 16'd65535, 16'd30, 16'd500, 16'd8, 16'd100};
        requests_sent = 0;
        calm = 0;
        hold_off = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_opcode = OP_TICK;
        i_task_index = '0;
        i_stack_pointer = '0;
        i_sleep_ms = '0;
        i_cfg_we = 0;
        i_cfg_index = CFG_QUANTUM;
        i_cfg_wdata = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Empty table: every per-task request is ignored, schedule echoes; then slots 0 and 7 are exercised.
        send_request(OP_SLEEP, 3'd0, 32'h1234_5678, 32'd50);
        send_request(OP_EXIT, 3'd0, 32'hFFFF_FFFF, 32'd0);
        send_request(OP_BEAT, 3'd7, 32'd0, 32'hFFFF_FFFF);
        send_request(OP_SCHED, 3'd0, 32'hA5A5_A5A5, 32'd0);
        send_request(OP_TICK, 3'd0, 32'd0, 32'd0);
        send_request(OpUndefLo, 3'd1, 32'd7, 32'd7);
        send_request(OpUndefHi, 3'd2, 32'd9, 32'd9);
        send_request(OP_CREATE, 3'd0, 32'h0000_0000, 32'd0);
        send_request(OP_CREATE, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_SCHED, 3'd0, 32'h5A5A_5A5A, 32'd0);
        send_request(OP_BEAT, 3'd0, 32'd1, 32'd0);
        send_request(OP_SLEEP, 3'd0, 32'd2, 32'd0);
        send_request(OP_SCHED, 3'd0, 32'h0F0F_0F0F, 32'd0);
        send_request(OP_SLEEP, 3'd0, 32'd3, 32'd9);
        send_request(OP_SCHED, 3'd0, 32'd4, 32'd0);
        send_request(OP_TICK, 3'd0, 32'd0, 32'd0);
        send_request(OP_TICK, 3'd0, 32'd0, 32'd0);
        send_request(OP_SCHED, 3'd0, 32'd5, 32'd0);
        send_request(OP_SLEEP, 3'd0, 32'd6, 32'hFFFF_FFFF);
        send_request(OP_SCHED, 3'd0, 32'd7, 32'd0);
        send_request(OP_EXIT, 3'd0, 32'd8, 32'd10);
        send_request(OP_SCHED, 3'd0, 32'd9, 32'd0);
        for (int i = 0; i < 3; i++)
            send_request(OP_TICK, 3'd0, 32'd0, 32'd0);

        for (int p = 0; p < 6; p++) begin
            drain();
            write_config(p == 3 ? 8'($urandom_range(1, 255)) : q_set[p],
                         p == 3 ? 16'($urandom_range(1, 65535)) : t_set[p]);
            calm = (p == 1);
            for (int n = 0; n < PhaseItems; n++) begin
                if (p == 2 && n == 100)
                    hold_off = 1;
                if (p == 4 && n == 150)
                    drain();
                random_request();
            end
            calm = 0;
        end
        drain();

        $display("%0d requests sent, %0d results checked over six register settings",
                 requests_sent, sched_sb.checked);
        if (sched_sb.errors == 0 && sched_sb.expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results missing", sched_sb.errors,
                     sched_sb.expected_q.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/rrts_pkg.sv
rtl/rrts_div10.sv
rtl/round_robin_task_scheduler.sv
tb/tb_round_robin_task_scheduler.sv
